FILE: rtl/dlr_pkg.sv
// ----------------------------------------------------------------------------
// dlr_pkg: shared types and constants of the dense layer unit
// Field widths, item kind codes, sequencer states and the pipeline tag.
// ----------------------------------------------------------------------------
`default_nettype none

package dlr_pkg;

	// default layer shape
	localparam int IN_SIZE_DEF  = 16;
	localparam int OUT_SIZE_DEF = 20;

	// field widths
	localparam int DATA_W   = 16;
	localparam int INDEX_W  = 9;
	localparam int NEURON_W = 5;
	localparam int ACT_W    = 15;
	localparam int FRAC_W   = 8;

	// what an input transaction writes
	typedef enum logic [1:0] {
		KIND_WEIGHT = 2'd0,
		KIND_BIAS   = 2'd1,
		KIND_INPUT  = 2'd2
	} kind_t;

	// sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DRAIN
	} state_t;

	// control tag that travels with each multiply-accumulate
	typedef struct packed {
		logic valid;
		logic first;
		logic last;
	} mac_tag_t;

endpackage

`default_nettype wire

FILE: rtl/dlr_ram.sv
// ----------------------------------------------------------------------------
// dlr_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module dlr_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 320
) (
	input  wire logic                               clk,
	input  wire logic                               we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                   wdata,
	input  wire logic                               re,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                   rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

FILE: rtl/dlr_mac.sv
// ----------------------------------------------------------------------------
// dlr_mac: shared multiply-accumulate unit with relu and saturation
// Registers one product per cycle while adv is high and folds it into the
// accumulator; presents the clamped Q7.8 activation once a neuron is done.
// ----------------------------------------------------------------------------
`default_nettype none

module dlr_mac #(
	parameter int IN_SIZE  = dlr_pkg::IN_SIZE_DEF,
	parameter int NEURON_IW = 5
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              adv,
	input  dlr_pkg::mac_tag_t                      tag_in,
	input  wire logic signed [dlr_pkg::DATA_W-1:0] x,
	input  wire logic signed [dlr_pkg::DATA_W-1:0] w,
	input  wire logic signed [dlr_pkg::DATA_W-1:0] bias,
	input  wire logic        [NEURON_IW-1:0]       neuron_in,
	output logic                                   done,
	output logic             [NEURON_IW-1:0]       neuron,
	output logic             [dlr_pkg::ACT_W-1:0]  activation
);

	localparam int PROD_W = 2 * dlr_pkg::DATA_W;
	localparam int ACC_W  = PROD_W + 1 + $clog2(IN_SIZE + 1);
	localparam int SAT_LO = dlr_pkg::ACT_W + dlr_pkg::FRAC_W;

	dlr_pkg::mac_tag_t                 tag_s2;
	logic signed [PROD_W-1:0]          prod_s2;
	logic signed [dlr_pkg::DATA_W-1:0] bias_s2;
	logic        [NEURON_IW-1:0]       neuron_s2;
	logic signed [ACC_W-1:0]           acc_q;
	logic                              done_q;
	logic        [NEURON_IW-1:0]       neuron_q;
	logic signed [ACC_W-1:0]           prod_ext;
	logic signed [ACC_W-1:0]           bias_ext;

	// control tags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s2 <= '0;
			done_q <= 1'b0;
		end else if (adv) begin
			tag_s2 <= tag_in;
			done_q <= tag_s2.valid && tag_s2.last;
		end
	end

	assign prod_ext = ACC_W'(prod_s2);
	assign bias_ext = ACC_W'(bias_s2) <<< dlr_pkg::FRAC_W;

	// product register and accumulator
	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s2   <= x * w;
			bias_s2   <= bias;
			neuron_s2 <= neuron_in;
			if (tag_s2.valid) begin
				if (tag_s2.first) begin
					acc_q <= bias_ext + prod_ext;
				end else begin
					acc_q <= acc_q + prod_ext;
				end
			end
			if (tag_s2.valid && tag_s2.last) begin
				neuron_q <= neuron_s2;
			end
		end
	end

	// relu, shift by the fraction width, saturate
	always_comb begin
		if (acc_q[ACC_W-1]) begin
			activation = '0;
		end else if (|acc_q[ACC_W-2:SAT_LO]) begin
			activation = {dlr_pkg::ACT_W{1'b1}};
		end else begin
			activation = acc_q[SAT_LO-1:dlr_pkg::FRAC_W];
		end
	end

	assign done   = done_q;
	assign neuron = neuron_q;

endmodule

`default_nettype wire

FILE: rtl/dense_layer_relu_unit.sv
// ----------------------------------------------------------------------------
// dense_layer_relu_unit: fully connected layer with relu, Q8.8 fixed point
// Loads weights, biases and inputs, then computes and streams the outputs.
// ----------------------------------------------------------------------------
// Each input transaction writes one weight (index input*OUT_SIZE+output), one
// bias or one input element. A transaction with tlast set starts a run
// after its own write: the sequencer walks all IN_SIZE*OUT_SIZE
// multiply-accumulates through one shared multiplier, one per cycle while the
// output is not stalled, reading the weight memory at one address a cycle.
// OUT_SIZE results follow in neuron order, the final one with tlast; s_tready
// stays low from the start of a run until that final result has been taken.
// Stores come up undefined after reset and need no clearing; writes past the
// end of a store are dropped.
`default_nettype none

module dense_layer_relu_unit #(
	parameter int IN_SIZE  = dlr_pkg::IN_SIZE_DEF,
	parameter int OUT_SIZE = dlr_pkg::OUT_SIZE_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// input stream
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,  // index[8:0], value[24:9], zeros above
	input  wire logic [1:0]  s_tuser,  // kind[1:0]
	input  wire logic        s_tlast,  // start_req
	// result stream
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [23:0] m_tdata,  // neuron[4:0], activation[19:5], zeros above
	output logic             m_tlast   // last
);

	localparam int W_DEPTH = IN_SIZE * OUT_SIZE;
	localparam int WAW     = (W_DEPTH > 1) ? $clog2(W_DEPTH) : 1;
	localparam int IW      = (IN_SIZE > 1) ? $clog2(IN_SIZE) : 1;
	localparam int OW      = (OUT_SIZE > 1) ? $clog2(OUT_SIZE) : 1;
	localparam int DW      = dlr_pkg::DATA_W;

	dlr_pkg::state_t   state_q, state_d;
	dlr_pkg::kind_t    kind;
	dlr_pkg::mac_tag_t tag_s1;

	logic                 s_acc;
	logic                 m_acc;
	logic                 adv;
	logic                 issue;
	logic                 issue_end;
	logic [31:0]          idx32;
	logic [dlr_pkg::INDEX_W-1:0] s_index;
	logic signed [DW-1:0] s_value;
	logic                 w_we;

	logic [IW-1:0]        i_q;
	logic [OW-1:0]        o_q;
	logic [WAW-1:0]       addr_q;
	logic [31:0]          addr_step;
	logic [31:0]          addr_next_o;

	logic signed [DW-1:0] input_q [IN_SIZE];
	logic signed [DW-1:0] bias_q  [OUT_SIZE];
	logic signed [DW-1:0] x_s1;
	logic signed [DW-1:0] b_s1;
	logic        [OW-1:0] neuron_s1;
	logic        [DW-1:0] w_rdata;

	logic                 mac_done;
	logic        [OW-1:0] mac_neuron;
	logic [dlr_pkg::ACT_W-1:0] mac_act;

	logic                 m_tvalid_q;
	logic [dlr_pkg::ACT_W-1:0] act_q;
	logic [dlr_pkg::NEURON_W-1:0] neuron_q;
	logic                 last_q;
	logic [31:0]          neuron32;

	// field unpacking
	assign s_index = s_tdata[dlr_pkg::INDEX_W-1:0];
	assign s_value = s_tdata[dlr_pkg::INDEX_W +: DW];
	assign kind    = dlr_pkg::kind_t'(s_tuser);
	assign idx32   = 32'(s_index);

	assign s_acc = s_tvalid && s_tready;
	assign m_acc = m_tvalid_q && m_tready;
	// the whole compute pipeline holds while a result waits
	assign adv   = !m_tvalid_q || m_tready;

	assign issue_end = (32'(i_q) == IN_SIZE - 1) && (32'(o_q) == OUT_SIZE - 1);

	// sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dlr_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			dlr_pkg::ST_IDLE: begin
				if (s_acc && s_tlast) begin
					state_d = dlr_pkg::ST_RUN;
				end
			end
			dlr_pkg::ST_RUN: begin
				if (adv && issue_end) begin
					state_d = dlr_pkg::ST_DRAIN;
				end
			end
			dlr_pkg::ST_DRAIN: begin
				if (m_acc && m_tlast) begin
					state_d = dlr_pkg::ST_IDLE;
				end
			end
			default: state_d = dlr_pkg::ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		s_tready = 1'b0;
		issue    = 1'b0;
		unique case (state_q)
			dlr_pkg::ST_IDLE:  s_tready = 1'b1;
			dlr_pkg::ST_RUN:   issue    = adv;
			dlr_pkg::ST_DRAIN: issue    = 1'b0;
			default: begin
				s_tready = 1'b0;
				issue    = 1'b0;
			end
		endcase
	end

	// loop counters and weight address walk
	assign addr_step   = 32'(addr_q) + OUT_SIZE;
	assign addr_next_o = 32'(o_q) + 1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q    <= '0;
			o_q    <= '0;
			addr_q <= '0;
		end else if (s_acc && s_tlast) begin
			i_q    <= '0;
			o_q    <= '0;
			addr_q <= '0;
		end else if (issue) begin
			if (32'(i_q) == IN_SIZE - 1) begin
				i_q    <= '0;
				o_q    <= addr_next_o[OW-1:0];
				addr_q <= addr_next_o[WAW-1:0];
			end else begin
				i_q    <= i_q + 1'b1;
				addr_q <= addr_step[WAW-1:0];
			end
		end
	end

	// bias and input element stores
	always_ff @(posedge clk) begin
		if (s_acc && kind == dlr_pkg::KIND_INPUT && idx32 < IN_SIZE) begin
			input_q[idx32[IW-1:0]] <= s_value;
		end
		if (s_acc && kind == dlr_pkg::KIND_BIAS && idx32 < OUT_SIZE) begin
			bias_q[idx32[OW-1:0]] <= s_value;
		end
	end

	assign w_we = s_acc && kind == dlr_pkg::KIND_WEIGHT && idx32 < W_DEPTH;

	// weight memory
	dlr_ram #(
		.WIDTH (DW),
		.DEPTH (W_DEPTH)
	) u_weight_ram (
		.clk   (clk),
		.we    (w_we),
		.waddr (idx32[WAW-1:0]),
		.wdata (s_value),
		.re    (issue),
		.raddr (addr_q),
		.rdata (w_rdata)
	);

	// issue stage tag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
		end else if (adv) begin
			tag_s1.valid <= issue;
			tag_s1.first <= (i_q == '0);
			tag_s1.last  <= (32'(i_q) == IN_SIZE - 1);
		end
	end

	// operands that line up with the weight read
	always_ff @(posedge clk) begin
		if (issue) begin
			x_s1      <= input_q[i_q];
			b_s1      <= bias_q[o_q];
			neuron_s1 <= o_q;
		end
	end

	dlr_mac #(
		.IN_SIZE   (IN_SIZE),
		.NEURON_IW (OW)
	) u_mac (
		.clk        (clk),
		.arst_n     (arst_n),
		.adv        (adv),
		.tag_in     (tag_s1),
		.x          (x_s1),
		.w          (w_rdata),
		.bias       (b_s1),
		.neuron_in  (neuron_s1),
		.done       (mac_done),
		.neuron     (mac_neuron),
		.activation (mac_act)
	);

	// output register
	assign neuron32 = 32'(mac_neuron);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (adv) begin
			m_tvalid_q <= mac_done;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && mac_done) begin
			act_q    <= mac_act;
			neuron_q <= neuron32[dlr_pkg::NEURON_W-1:0];
			last_q   <= (neuron32 == OUT_SIZE - 1);
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {4'b0000, act_q, neuron_q};
	assign m_tlast  = last_q;

`ifndef SYNTHESIS
	// no load may be taken while results are still pending
	a_no_load_with_result: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid))
		else $error("input accepted while a result is pending");

	// pipeline is empty whenever the unit is idle
	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == dlr_pkg::ST_IDLE) |-> (!tag_s1.valid && !mac_done))
		else $error("compute pipeline busy while idle");

	// a start transaction begins a run
	a_start_runs: assert property (@(posedge clk) disable iff (!arst_n)
		(s_acc && s_tlast) |=> (state_q == dlr_pkg::ST_RUN))
		else $error("start did not begin a run");

	// the final result ends the run
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(m_acc && m_tlast) |=> (state_q == dlr_pkg::ST_IDLE && !m_tvalid))
		else $error("run did not end after final result");
`endif

endmodule

`default_nettype wire
